// ----- rtl/pds_pkg.sv -----
// shared constants and widths for the pll divider search
package pds_pkg;

  // search limits
  localparam int MAX_N = 511;
  localparam int MAX_M = 15;

  // field widths fixed by the interface
  localparam int FREQ_W   = 28;
  localparam int STATUS_W = 2;
  localparam int M_OUT_W  = 4;
  localparam int N_OUT_W  = 9;

  // derived widths
  localparam int N_W   = (MAX_N < 1) ? 1 : $clog2(MAX_N + 1);
  localparam int MUL_W = $clog2(MAX_N + 3);
  localparam int NUM_W = FREQ_W + MUL_W;
  localparam int DEN_W = FREQ_W + 2;
  localparam int P_W   = $clog2(MAX_M + 3);
  localparam int CNT_W = $clog2(NUM_W);

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ----- rtl/pds_divider.sv -----
// shared iterative restoring divider, one quotient bit per cycle
module pds_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pds_pkg::NUM_W-1:0]  dividend,
  input  logic [pds_pkg::DEN_W-1:0]  divisor,
  output logic                       done,
  output logic [pds_pkg::NUM_W-1:0]  quotient
);
  import pds_pkg::*;

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
        cnt     <= CNT_W'(NUM_W - 1);
      end else if (running) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], ge};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/pll_divider_search.sv -----
// pll divider search: sequencer around one shared iterative divider
//
// Each transaction takes ref_freq and target_freq and returns the feedback
// value pll_n, the divider pll_m and m_bypass for a post divider fixed at 2.
// Candidates N = 0 .. MAX_N are tried in turn; each takes two divisions on
// one restoring divider that produces one quotient bit per cycle over a
// 38-bit dividend, and a candidate is skipped after the first division
// when its quotient is zero. The search stops early on an exact match, and
// a zero frequency goes straight to the result without any division.
// The block takes one transaction at a time: in_stall is high from acceptance
// until the result has been placed in the output register.
module pll_divider_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pds_pkg::FREQ_W-1:0]     ref_freq,
  input  logic [pds_pkg::FREQ_W-1:0]     target_freq,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pds_pkg::STATUS_W-1:0]   status,
  output logic [pds_pkg::M_OUT_W-1:0]    pll_m,
  output logic [pds_pkg::N_OUT_W-1:0]    pll_n,
  output logic                           m_bypass
);
  import pds_pkg::*;

  localparam int N_EXT_W = (N_W > N_OUT_W) ? N_W : N_OUT_W;
  localparam int M_EXT_W = (P_W > M_OUT_W) ? P_W : M_OUT_W;
  localparam logic [P_W-1:0] P_CAP = P_W'(MAX_M + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_NEXT,
    S_FINISH
  } state_t;

  state_t              state;
  logic [FREQ_W-1:0]   refv;
  logic [FREQ_W-1:0]   tgt;
  logic [NUM_W-1:0]    num;
  logic [N_W-1:0]      n;
  logic                found;
  logic [NUM_W-1:0]    best;
  logic [N_W-1:0]      best_n;
  logic [P_W-1:0]      best_p;
  logic [P_W-1:0]      p;
  logic [STATUS_W-1:0] res_status;

  logic                div_start;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;

  logic [P_W-1:0]      p_cand;
  logic [P_W-1:0]      m_val;
  logic [M_EXT_W-1:0]  m_ext;
  logic [N_EXT_W-1:0]  n_ext;
  logic                out_free;

  pds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // capped M+2 from the first quotient, and the result fields
  always_comb begin
    p_cand   = (div_quo > NUM_W'(P_CAP)) ? P_CAP : div_quo[P_W-1:0];
    m_val    = (best_p < P_W'(2)) ? '0 : best_p - P_W'(2);
    m_ext    = M_EXT_W'(m_val);
    n_ext    = N_EXT_W'(best_n);
    out_free = !out_valid || !out_stall;
  end

  assign in_stall = (state != S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      found     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            refv  <= ref_freq;
            tgt   <= target_freq;
            num   <= NUM_W'({ref_freq, 1'b0});
            n     <= '0;
            found <= 1'b0;
            if (ref_freq == '0 || target_freq == '0) begin
              res_status <= ST_ZERO;
              state      <= S_FINISH;
            end else begin
              div_divisor <= {target_freq, 2'b00};
              div_start   <= 1'b1;
              state       <= S_DIV1;
            end
          end
        end
        // first division gives M+2
        S_DIV1: begin
          if (div_done) begin
            if (p_cand == '0) begin
              state <= S_NEXT;
            end else begin
              p           <= p_cand;
              div_divisor <= DEN_W'({p_cand, 2'b00});
              div_start   <= 1'b1;
              state       <= S_DIV2;
            end
          end
        end
        // second division gives the output frequency
        S_DIV2: begin
          if (div_done) begin
            if (!found || div_quo < best) begin
              found  <= 1'b1;
              best   <= div_quo;
              best_n <= n;
              best_p <= p;
            end
            if (div_quo == NUM_W'(tgt)) begin
              res_status <= ST_OK;
              state      <= S_FINISH;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        // step to the next candidate or close the search
        S_NEXT: begin
          if (n == N_W'(MAX_N)) begin
            res_status <= found ? ST_OK : ST_RANGE;
            state      <= S_FINISH;
          end else begin
            n           <= n + 1'b1;
            num         <= num + NUM_W'(refv);
            div_divisor <= {tgt, 2'b00};
            div_start   <= 1'b1;
            state       <= S_DIV1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            if (res_status == ST_OK) begin
              pll_m    <= m_ext[M_OUT_W-1:0];
              pll_n    <= n_ext[N_OUT_W-1:0];
              m_bypass <= (best_p == P_W'(1));
            end else begin
              pll_m    <= '0;
              pll_n    <= '0;
              m_bypass <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
